// ===== rtl/core/lorentz_trip_times_unit_macros.svh =====
// assertion helpers for the lorentz trip times unit
`ifndef LORENTZ_TRIP_TIMES_UNIT_MACROS_SVH
`define LORENTZ_TRIP_TIMES_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define LTT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");
`define LTT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define LTT_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LTT_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== rtl/core/ltt_pkg.sv =====
`default_nettype none
package ltt_pkg;

  // field widths
  localparam int unsigned DIST_W  = 47;
  localparam int unsigned BETA_W  = 32;
  localparam int unsigned GAMMA_W = 32;
  localparam int unsigned TIME_W  = 64;

  // unity in Q16.16
  localparam logic [GAMMA_W-1:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [BETA_W-1:0]  MAX_BETA_RST = 32'hFFFF_FE52;

  // divider chain numerator widths, and the reciprocal's divisor width
  localparam int unsigned GINV_NW   = 97;  // 2^96 / (1 - b^2)
  localparam int unsigned GINV_DW   = 64;
  localparam int unsigned COORD_NW  = DIST_W + 32;
  localparam int unsigned PROPER_NW = COORD_NW + 16;
  localparam int unsigned CONTR_NW  = DIST_W + 16;

  // square root chain
  localparam int unsigned RAD_W     = 64;
  localparam int unsigned SQ_REM_W  = 34;
  localparam int unsigned SQ_STEPS  = 32;

  // pipeline timing, counted in cycles after the request edge
  localparam int unsigned LAT_GINV  = 2 + GINV_NW;
  localparam int unsigned LAT_GAMMA = LAT_GINV + SQ_STEPS;
  localparam int unsigned LAT_COORD = 1 + COORD_NW;
  localparam int unsigned LAT_END   = LAT_GAMMA + PROPER_NW;
  localparam int unsigned LAT_CONTR = LAT_GAMMA + CONTR_NW;

endpackage
`default_nettype wire

// ===== rtl/core/ltt_div_cell.sv =====
`default_nettype none
module ltt_div_cell #(
  parameter int unsigned NW = 8,
  parameter int unsigned DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] rem_i,
  input  wire logic [NW-1:0] quo_i,
  input  wire logic [DW-1:0] dv_i,
  output logic      [NW-1:0] num_o,
  output logic      [DW-1:0] rem_o,
  output logic      [NW-1:0] quo_o,
  output logic      [DW-1:0] dv_o
);

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;
  logic [NW-1:0] num_d, quo_d;
  logic [DW-1:0] rem_d;
  logic [NW-1:0] num_q, quo_q;
  logic [DW-1:0] rem_q, dv_q;

  // one restoring step: bring down the next numerator bit
  always_comb begin
    trial = {rem_i, num_i[NW-1]};
    diff  = trial - {1'b0, dv_i};
    ge    = (trial >= {1'b0, dv_i});
    rem_d = ge ? diff[DW-1:0] : trial[DW-1:0];
    num_d = {num_i[NW-2:0], 1'b0};
    quo_d = {quo_i[NW-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dv_q  <= dv_i;
  end

  assign num_o = num_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign dv_o  = dv_q;

endmodule
`default_nettype wire

// ===== rtl/core/ltt_sqrt_cell.sv =====
`default_nettype none
module ltt_sqrt_cell (
  input  wire logic                          clk_i,
  input  wire logic [ltt_pkg::RAD_W-1:0]     rad_i,
  input  wire logic [ltt_pkg::SQ_REM_W-1:0]  rem_i,
  input  wire logic [ltt_pkg::SQ_STEPS-1:0]  root_i,
  output logic      [ltt_pkg::RAD_W-1:0]     rad_o,
  output logic      [ltt_pkg::SQ_REM_W-1:0]  rem_o,
  output logic      [ltt_pkg::SQ_STEPS-1:0]  root_o
);

  logic [ltt_pkg::SQ_REM_W+1:0] trial, tst, diff;
  logic                         ge;
  logic [ltt_pkg::RAD_W-1:0]    rad_d, rad_q;
  logic [ltt_pkg::SQ_REM_W-1:0] rem_d, rem_q;
  logic [ltt_pkg::SQ_STEPS-1:0] root_d, root_q;

  // one root bit per step from the next two radicand bits
  always_comb begin
    trial  = {rem_i, rad_i[ltt_pkg::RAD_W-1 -: 2]};
    tst    = {2'b00, root_i, 2'b01};
    diff   = trial - tst;
    ge     = (trial >= tst);
    rem_d  = ge ? diff[ltt_pkg::SQ_REM_W-1:0] : trial[ltt_pkg::SQ_REM_W-1:0];
    root_d = {root_i[ltt_pkg::SQ_STEPS-2:0], ge};
    rad_d  = {rad_i[ltt_pkg::RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign rad_o  = rad_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule
`default_nettype wire

// ===== rtl/core/ltt_delay.sv =====
`default_nettype none
module ltt_delay #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 2
) (
  input  wire logic         clk_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] d_o
);

  logic [W-1:0] tap_q [N];

  // plain shift line, payload only
  always_ff @(posedge clk_i) begin
    tap_q[0] <= d_i;
    for (int k = 1; k < N; k++) begin
      tap_q[k] <= tap_q[k-1];
    end
  end

  assign d_o = tap_q[N-1];

endmodule
`default_nettype wire

// ===== rtl/core/lorentz_trip_times_unit.sv =====
`default_nettype none
// Relativistic trip calculator. A request is taken in every cycle (busy
// stays low) and its result appears on the registered result ports, with
// valid_o high for one cycle. The receiver cannot stall, so results
// must be captured when valid_o is high. The result path runs through the
// clamp and square stages, the chains of one-bit divider cells (97 for
// the gamma reciprocal, 95 for proper time), the 32-cell square root chain
// and the result register. max_beta is sampled when a request is taken;
// write it only while no request is in flight.
`include "lorentz_trip_times_unit_macros.svh"
module lorentz_trip_times_unit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic signed [47:0]    distance_i,
  input  wire logic signed [33:0]    speed_fraction_i,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [31:0]           cfg_data,
  output logic                       valid_o,
  output logic [31:0]                used_beta_o,
  output logic [31:0]                lorentz_gamma_o,
  output logic [63:0]                coordinate_time_o,
  output logic [63:0]                proper_time_o,
  output logic [46:0]                contracted_distance_o,
  output logic                       saturated_o
);

  localparam int unsigned DW  = ltt_pkg::DIST_W;
  localparam int unsigned BW  = ltt_pkg::BETA_W;
  localparam int unsigned GW  = ltt_pkg::GAMMA_W;
  localparam int unsigned CNW = ltt_pkg::COORD_NW;
  localparam int unsigned PNW = ltt_pkg::PROPER_NW;
  localparam int unsigned XNW = ltt_pkg::CONTR_NW;
  localparam int unsigned INW = ltt_pkg::GINV_NW;
  localparam int unsigned IDW = ltt_pkg::GINV_DW;
  localparam int unsigned TW  = ltt_pkg::TIME_W;

  logic [BW-1:0] max_beta_q;
  logic          accept;
  logic [ltt_pkg::LAT_END-1:0] vld_q;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_beta_q <= ltt_pkg::MAX_BETA_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_beta_q <= cfg_data;
    end
  end

  // valid tracking down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[ltt_pkg::LAT_END-2:0], accept};
    end
  end

  // clamp distance and beta
  logic [DW-1:0] d_s0_d, d_s0_q;
  logic [BW-1:0] b_s0_d, b_s0_q;
  always_comb begin
    d_s0_d = distance_i[47] ? '0 : distance_i[DW-1:0];
    if (speed_fraction_i[33]) begin
      b_s0_d = '0;
    end else if (speed_fraction_i[32:0] > {1'b0, max_beta_q}) begin
      b_s0_d = max_beta_q;
    end else begin
      b_s0_d = speed_fraction_i[BW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    d_s0_q <= d_s0_d;
    b_s0_q <= b_s0_d;
  end

  // beta squared, then 1 - b^2 in Q0.64
  logic [2*BW-1:0] bb_q;
  logic [IDW-1:0]  p_w;
  always_ff @(posedge clk_i) begin
    bb_q <= b_s0_q * b_s0_q;
  end
  assign p_w = '0 - bb_q;

  // reciprocal chain: floor(2^96 / p)
  logic [INW-1:0] gi_num [INW+1];
  logic [IDW-1:0] gi_rem [INW+1];
  logic [INW-1:0] gi_quo [INW+1];
  logic [IDW-1:0] gi_dv  [INW+1];
  assign gi_num[0] = {1'b1, {(INW-1){1'b0}}};
  assign gi_rem[0] = '0;
  assign gi_quo[0] = '0;
  assign gi_dv[0]  = p_w;

  for (genvar k = 0; k < INW; k++) begin : g_ginv
    ltt_div_cell #(.NW(INW), .DW(IDW)) u_cell (
      .clk_i (clk_i),
      .num_i (gi_num[k]), .rem_i (gi_rem[k]), .quo_i (gi_quo[k]), .dv_i (gi_dv[k]),
      .num_o (gi_num[k+1]), .rem_o (gi_rem[k+1]), .quo_o (gi_quo[k+1]),
      .dv_o  (gi_dv[k+1])
    );
  end

  // square root chain gives gamma in Q16.16
  logic [ltt_pkg::RAD_W-1:0]    sq_rad  [ltt_pkg::SQ_STEPS+1];
  logic [ltt_pkg::SQ_REM_W-1:0] sq_rem  [ltt_pkg::SQ_STEPS+1];
  logic [ltt_pkg::SQ_STEPS-1:0] sq_root [ltt_pkg::SQ_STEPS+1];
  assign sq_rad[0]  = gi_quo[INW][ltt_pkg::RAD_W-1:0];
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < ltt_pkg::SQ_STEPS; k++) begin : g_sqrt
    ltt_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rad_i  (sq_rad[k]), .rem_i (sq_rem[k]), .root_i (sq_root[k]),
      .rad_o  (sq_rad[k+1]), .rem_o (sq_rem[k+1]), .root_o (sq_root[k+1])
    );
  end

  // distance and beta aligned with gamma
  logic [DW-1:0] d_g, d_e;
  logic [BW-1:0] b_g, b_e;
  logic [GW-1:0] g_w, g_e;
  ltt_delay #(.W(DW), .N(ltt_pkg::LAT_GAMMA-1)) u_dly_d1 (
    .clk_i (clk_i), .d_i (d_s0_q), .d_o (d_g));
  ltt_delay #(.W(BW), .N(ltt_pkg::LAT_GAMMA-1)) u_dly_b1 (
    .clk_i (clk_i), .d_i (b_s0_q), .d_o (b_g));
  assign g_w = (b_g == '0) ? ltt_pkg::ONE_Q16 : sq_root[ltt_pkg::SQ_STEPS];

  // coordinate time chain: (d << 32) / b
  logic [CNW-1:0] co_num [CNW+1];
  logic [BW-1:0]  co_rem [CNW+1];
  logic [CNW-1:0] co_quo [CNW+1];
  logic [BW-1:0]  co_dv  [CNW+1];
  assign co_num[0] = {d_s0_q, {BW{1'b0}}};
  assign co_rem[0] = '0;
  assign co_quo[0] = '0;
  assign co_dv[0]  = b_s0_q;

  for (genvar k = 0; k < CNW; k++) begin : g_coord
    ltt_div_cell #(.NW(CNW), .DW(BW)) u_cell (
      .clk_i (clk_i),
      .num_i (co_num[k]), .rem_i (co_rem[k]), .quo_i (co_quo[k]), .dv_i (co_dv[k]),
      .num_o (co_num[k+1]), .rem_o (co_rem[k+1]), .quo_o (co_quo[k+1]),
      .dv_o  (co_dv[k+1])
    );
  end

  logic [CNW-1:0] c_g, c_e;
  ltt_delay #(.W(CNW), .N(ltt_pkg::LAT_GAMMA-ltt_pkg::LAT_COORD)) u_dly_c1 (
    .clk_i (clk_i), .d_i (co_quo[CNW]), .d_o (c_g));

  // proper time chain: (C << 16) / g
  logic [PNW-1:0] pr_num [PNW+1];
  logic [GW-1:0]  pr_rem [PNW+1];
  logic [PNW-1:0] pr_quo [PNW+1];
  logic [GW-1:0]  pr_dv  [PNW+1];
  assign pr_num[0] = {c_g, 16'h0000};
  assign pr_rem[0] = '0;
  assign pr_quo[0] = '0;
  assign pr_dv[0]  = g_w;

  for (genvar k = 0; k < PNW; k++) begin : g_proper
    ltt_div_cell #(.NW(PNW), .DW(GW)) u_cell (
      .clk_i (clk_i),
      .num_i (pr_num[k]), .rem_i (pr_rem[k]), .quo_i (pr_quo[k]), .dv_i (pr_dv[k]),
      .num_o (pr_num[k+1]), .rem_o (pr_rem[k+1]), .quo_o (pr_quo[k+1]),
      .dv_o  (pr_dv[k+1])
    );
  end

  // contracted distance chain: (d << 16) / g
  logic [XNW-1:0] cd_num [XNW+1];
  logic [GW-1:0]  cd_rem [XNW+1];
  logic [XNW-1:0] cd_quo [XNW+1];
  logic [GW-1:0]  cd_dv  [XNW+1];
  assign cd_num[0] = {d_g, 16'h0000};
  assign cd_rem[0] = '0;
  assign cd_quo[0] = '0;
  assign cd_dv[0]  = g_w;

  for (genvar k = 0; k < XNW; k++) begin : g_contr
    ltt_div_cell #(.NW(XNW), .DW(GW)) u_cell (
      .clk_i (clk_i),
      .num_i (cd_num[k]), .rem_i (cd_rem[k]), .quo_i (cd_quo[k]), .dv_i (cd_dv[k]),
      .num_o (cd_num[k+1]), .rem_o (cd_rem[k+1]), .quo_o (cd_quo[k+1]),
      .dv_o  (cd_dv[k+1])
    );
  end

  // align everything with the proper time quotient
  logic [XNW-1:0] x_e;
  ltt_delay #(.W(DW), .N(PNW)) u_dly_d2 (.clk_i (clk_i), .d_i (d_g), .d_o (d_e));
  ltt_delay #(.W(BW), .N(PNW)) u_dly_b2 (.clk_i (clk_i), .d_i (b_g), .d_o (b_e));
  ltt_delay #(.W(GW), .N(PNW)) u_dly_g2 (.clk_i (clk_i), .d_i (g_w), .d_o (g_e));
  ltt_delay #(.W(CNW), .N(PNW)) u_dly_c2 (.clk_i (clk_i), .d_i (c_g), .d_o (c_e));
  ltt_delay #(.W(XNW), .N(ltt_pkg::LAT_END-ltt_pkg::LAT_CONTR)) u_dly_x (
    .clk_i (clk_i), .d_i (cd_quo[XNW]), .d_o (x_e));

  // saturation, special cases and the result register
  logic          zero_w, c_sat, p_sat;
  logic [TW-1:0] coord_d, proper_d;
  logic [DW-1:0] contr_d;
  logic          sat_d;
  always_comb begin
    zero_w   = (b_e == '0) || (d_e == '0);
    c_sat    = |c_e[CNW-1:TW];
    p_sat    = |pr_quo[PNW][PNW-1:TW];
    coord_d  = c_sat ? '1 : c_e[TW-1:0];
    proper_d = p_sat ? '1 : pr_quo[PNW][TW-1:0];
    contr_d  = x_e[DW-1:0];
    sat_d    = c_sat || p_sat;
    if (zero_w) begin
      coord_d  = '0;
      proper_d = '0;
      contr_d  = d_e;
      sat_d    = 1'b0;
    end
  end

  logic valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vld_q[ltt_pkg::LAT_END-1];
    end
  end

  always_ff @(posedge clk_i) begin
    used_beta_o           <= b_e;
    lorentz_gamma_o       <= g_e;
    coordinate_time_o     <= coord_d;
    proper_time_o         <= proper_d;
    contracted_distance_o <= contr_d;
    saturated_o           <= sat_d;
  end

  assign valid_o = valid_q;

  // checks
  `LTT_ASSERT_IMP(a_gamma_floor, clk_i, rst_ni, valid_o, lorentz_gamma_o >= ltt_pkg::ONE_Q16)
  `LTT_ASSERT_IMP(a_sat_clips, clk_i, rst_ni, valid_o && saturated_o, (coordinate_time_o == '1) || (proper_time_o == '1))
  `LTT_ASSERT_IMP(a_rest_zero, clk_i, rst_ni, valid_o && (used_beta_o == '0), (coordinate_time_o == '0) && (proper_time_o == '0) && !saturated_o)

endmodule
`default_nettype wire

// ===== tb/lorentz_trip_times_unit_tb.sv =====
`default_nettype none
module lorentz_trip_times_unit_tb;

  // one trip result as seen on the result ports
  typedef struct packed {
    logic [31:0] beta;
    logic [31:0] gamma;
    logic [63:0] coord;
    logic [63:0] proper;
    logic [46:0] contr;
    logic        sat;
  } trip_t;

  // in-order store of predicted trip results
  class trip_scoreboard;
    trip_t pending[$];
    int    fails;
    int    seen;

    function void note_request(trip_t exp_res);
      pending.push_back(exp_res);
    endfunction

    function void check_result(trip_t got);
      trip_t exp_res;
      seen++;
      if (pending.size() == 0) begin
        $error("result with no request pending");
        fails++;
        return;
      end
      exp_res = pending.pop_front();
      if (got.beta !== exp_res.beta) begin
        $error("used_beta: expected %0h actual %0h", exp_res.beta, got.beta);
        fails++;
      end
      if (got.gamma !== exp_res.gamma) begin
        $error("lorentz_gamma: expected %0h actual %0h", exp_res.gamma, got.gamma);
        fails++;
      end
      if (got.coord !== exp_res.coord) begin
        $error("coordinate_time: expected %0h actual %0h", exp_res.coord, got.coord);
        fails++;
      end
      if (got.proper !== exp_res.proper) begin
        $error("proper_time: expected %0h actual %0h", exp_res.proper, got.proper);
        fails++;
      end
      if (got.contr !== exp_res.contr) begin
        $error("contracted_distance: expected %0h actual %0h", exp_res.contr, got.contr);
        fails++;
      end
      if (got.sat !== exp_res.sat) begin
        $error("saturated: expected %0h actual %0h", exp_res.sat, got.sat);
        fails++;
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [47:0] distance_i;
  logic signed [33:0] speed_fraction_i;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [31:0]        cfg_data;
  logic               valid_o;
  logic [31:0]        used_beta_o;
  logic [31:0]        lorentz_gamma_o;
  logic [63:0]        coordinate_time_o;
  logic [63:0]        proper_time_o;
  logic [46:0]        contracted_distance_o;
  logic               saturated_o;

  trip_scoreboard sb;
  logic [31:0]    beta_limit;
  int             n_requests;
  int             n_cfg;

  lorentz_trip_times_unit u_top (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .distance_i           (distance_i),
    .speed_fraction_i     (speed_fraction_i),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_data             (cfg_data),
    .valid_o              (valid_o),
    .used_beta_o          (used_beta_o),
    .lorentz_gamma_o      (lorentz_gamma_o),
    .coordinate_time_o    (coordinate_time_o),
    .proper_time_o        (proper_time_o),
    .contracted_distance_o(contracted_distance_o),
    .saturated_o          (saturated_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // gamma, times and contracted distance for one trip
  function automatic trip_t predict_trip(logic signed [47:0] trip_d,
                                         logic signed [33:0] spd,
                                         logic [31:0] lim);
    trip_t       r;
    logic [46:0] d;
    logic [31:0] b;
    logic [63:0] g;
    logic [63:0] c;
    logic [63:0] one_minus_b2;
    logic [127:0] prod;
    logic [127:0] q;
    logic [127:0] pq;
    d = trip_d[47] ? 47'd0 : trip_d[46:0];
    if (spd[33]) b = 32'd0;
    else if ({1'b0, spd[32:0]} > {2'b00, lim}) b = lim;
    else b = spd[31:0];
    // bitwise search for the largest g with g^2 * (2^64 - b^2) <= 2^96
    if (b == 32'd0) begin
      g = 64'd65536;
    end else begin
      one_minus_b2 = 64'd0 - ({32'd0, b} * {32'd0, b});
      g = 64'd0;
      for (int i = 31; i >= 0; i--) begin
        c = g | (64'd1 << i);
        prod = ({64'd0, c} * {64'd0, c}) * {64'd0, one_minus_b2};
        if (prod <= (128'd1 << 96)) g = c;
      end
    end
    r.beta   = b;
    r.gamma  = g[31:0];
    r.coord  = 64'd0;
    r.proper = 64'd0;
    r.sat    = 1'b0;
    if (b == 32'd0 || d == 47'd0) begin
      r.contr = d;
    end else begin
      q = {49'd0, d, 32'd0} / {96'd0, b};
      if (q[127:64] != 64'd0) begin
        r.coord = '1;
        r.sat   = 1'b1;
      end else begin
        r.coord = q[63:0];
      end
      pq = (q << 16) / {64'd0, g};
      if (pq[127:64] != 64'd0) begin
        r.proper = '1;
        r.sat    = 1'b1;
      end else begin
        r.proper = pq[63:0];
      end
      q = {65'd0, d, 16'd0} / {64'd0, g};
      r.contr = q[46:0];
    end
    return r;
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      sb.check_result({used_beta_o, lorentz_gamma_o, coordinate_time_o, proper_time_o,
                       contracted_distance_o, saturated_o});
    end
  end

  // issue one request, then idle for the given number of cycles
  task automatic send_trip(logic signed [47:0] trip_d, logic signed [33:0] spd, int gap);
    @(negedge clk_i);
    start            = 1'b1;
    distance_i       = trip_d;
    speed_fraction_i = spd;
    do @(posedge clk_i); while (busy);
    sb.note_request(predict_trip(trip_d, spd, beta_limit));
    n_requests++;
    if (gap > 0) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // wait for every result, then write max_beta
  task automatic write_max_beta(logic [31:0] val);
    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data  = val;
    do @(posedge clk_i); while (!cfg_ready);
    beta_limit = val;
    n_cfg++;
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  function automatic logic signed [47:0] pick_distance();
    case ($urandom_range(0, 9))
      0: return 48'sd0;
      1: return {1'b1, 15'($urandom), $urandom};
      2: return 48'h7FFF_FFFF_FFFF;
      3: return 48'($urandom_range(0, 32'hFFFFF));
      4: return {1'b0, 15'($urandom_range(0, 15)), $urandom};
      default: return {16'($urandom), $urandom};
    endcase
  endfunction

  function automatic logic signed [33:0] pick_speed();
    case ($urandom_range(0, 9))
      0: return 34'sd0;
      1: return {1'b1, 1'($urandom), $urandom};
      2: return {2'b00, beta_limit} + 34'($urandom_range(0, 1000));
      3: return {2'b00, beta_limit} - 34'($urandom_range(0, 1000));
      4: return 34'($urandom_range(1, 65535));
      5: return {2'b01, $urandom};
      default: return {2'($urandom), $urandom};
    endcase
  endfunction

  // stimulus
  initial begin
    logic [31:0] limits[6];
    sb               = new();
    rst_ni           = 1'b0;
    start            = 1'b0;
    distance_i       = '0;
    speed_fraction_i = '0;
    cfg_valid        = 1'b0;
    cfg_data         = '0;
    beta_limit       = ltt_pkg::MAX_BETA_RST;
    n_requests       = 0;
    n_cfg            = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed corners under the reset limit
    send_trip(48'sd0, 34'sd0, 0);
    send_trip(48'h7FFF_FFFF_FFFF, 34'h0_FFFF_FFFF, 0);
    send_trip(48'h7FFF_FFFF_FFFF, 34'h1_FFFF_FFFF, 1);
    send_trip(-48'sd1, 34'sd12345, 0);
    send_trip(48'h8000_0000_0000, 34'h0_8000_0000, 2);
    send_trip(48'sd65536, 34'sd0, 0);
    send_trip(48'sd65536, -34'sd1, 0);
    send_trip(48'sd65536, 34'h2_0000_0000, 0);
    send_trip(48'sd1, 34'sd1, 3);
    send_trip(48'h7FFF_FFFF_FFFF, 34'sd1, 0);
    send_trip(48'sd0, 34'h0_8000_0000, 0);
    send_trip(48'sd65536, 34'h0_8000_0000, 0);
    send_trip(48'sd65536, {2'b00, ltt_pkg::MAX_BETA_RST}, 0);
    send_trip(48'sd1, {2'b00, ltt_pkg::MAX_BETA_RST}, 0);
    send_trip(48'h0000_7FFF_FFFF, 34'h0_0001_0000, 0);

    // random phases, each under its own limit
    limits[0] = ltt_pkg::MAX_BETA_RST;
    limits[1] = 32'd0;
    limits[2] = 32'hFFFF_FFFF;
    limits[3] = 32'd1;
    limits[4] = $urandom;
    limits[5] = 32'h8000_0000 + $urandom_range(0, 32'h7FFF_FFFF);
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) write_max_beta(limits[ph]);
      for (int k = 0; k < 150; k++) begin
        send_trip(pick_distance(), pick_speed(), (ph == 2) ? 0 : $urandom_range(0, 9));
      end
    end
    write_max_beta(ltt_pkg::MAX_BETA_RST);
    send_trip(48'h7FFF_FFFF_FFFF, 34'h1_FFFF_FFFF, 0);

    @(negedge clk_i);
    start = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    $display("%0d trip requests over %0d max_beta writes, %0d results checked",
             n_requests, n_cfg, sb.seen);
    if (sb.fails == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
